@@ rtl/core/mbrp_pkg.sv @@
// Shared types and constants for the monochrome bitmap row packer.
`timescale 1ns / 1ps

package mbrp_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 10;
  localparam int unsigned ColW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ExtraW   = 2;

  localparam logic [SumW-1:0] WhiteSumMin = 10'd384;
  localparam logic [ColW-1:0] WidthReset  = 16'd720;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic              load;
    logic [ByteW-1:0]  first_byte;
    logic [ExtraW-1:0] extra;
    logic              row_end;
  } burst_t;

  typedef struct packed {
    logic more;
  } out_stat_t;

endpackage

@@ rtl/core/mbrp_pixel_reg.sv @@
// Input register holding one pixel transaction until the packer takes it.
`timescale 1ns / 1ps

module mbrp_pixel_reg import mbrp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  pixel_t in_pixel_i,
  output logic   pix_valid_o,
  input  logic   pix_take_i,
  output pixel_t pix_o
);

  logic   valid_q, valid_d;
  pixel_t pix_q;
  logic   load;

  assign in_ready_o = !valid_q || pix_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pix_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= in_pixel_i;
    end
  end

  assign pix_valid_o = valid_q;
  assign pix_o       = pix_q;

endmodule

@@ rtl/core/mbrp_row_packer.sv @@
// Threshold, bit shift, column count and row padding burst generation.
`timescale 1ns / 1ps

module mbrp_row_packer import mbrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ColW-1:0]  cfg_wdata_i,
  input  logic             step_i,
  input  pixel_t           pix_i,
  output burst_t           burst_o
);

  logic [ColW-1:0]  width_q;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ColW-1:0]  count_q, count_d;

  logic [SumW-1:0]  sum;
  logic             pix_bit;
  logic [ByteW-1:0] shift_new;
  logic [ColW-1:0]  count_new;
  logic [2:0]       fill;
  logic [2:0]       pad_bits;
  logic [1:0]       word_pos;
  logic             row_end;

  assign sum       = SumW'(pix_i.red) + SumW'(pix_i.green) + SumW'(pix_i.blue);
  assign pix_bit   = (sum >= WhiteSumMin);
  assign shift_new = {shift_q[ByteW-2:0], pix_bit};
  assign count_new = count_q + ColW'(1);
  assign fill      = count_new[2:0];
  assign pad_bits  = 3'd0 - fill;
  assign word_pos  = count_new[4:3];
  assign row_end   = (count_new == width_q);

  always_comb begin
    burst_o.load       = step_i && (row_end || (fill == 3'd0));
    burst_o.row_end    = row_end;
    burst_o.first_byte = shift_new;
    burst_o.extra      = '0;
    if (row_end) begin
      if (fill == 3'd0) begin
        burst_o.extra = 2'd0 - word_pos;
      end else begin
        burst_o.first_byte = shift_new << pad_bits;
        burst_o.extra      = 2'd3 - word_pos;
      end
    end
    shift_d = shift_q;
    count_d = count_q;
    if (step_i) begin
      shift_d = row_end ? '0 : shift_new;
      count_d = row_end ? '0 : count_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      shift_q <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      shift_q <= shift_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/core/mbrp_byte_out.sv @@
// Output register that plays out a byte burst, padding bytes as zeros.
`timescale 1ns / 1ps

module mbrp_byte_out import mbrp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  burst_t           burst_i,
  output logic             free_o,
  output out_stat_t        stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic              valid_q, valid_d;
  logic [ExtraW-1:0] extra_q, extra_d;
  logic              row_q, row_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              done;

  assign done   = valid_q && out_ready_i;
  assign free_o = !valid_q || (out_ready_i && (extra_q == '0));

  always_comb begin
    valid_d = valid_q;
    extra_d = extra_q;
    row_d   = row_q;
    byte_d  = byte_q;
    if (done && (extra_q != '0)) begin
      byte_d  = '0;
      extra_d = extra_q - ExtraW'(1);
    end else if (free_o) begin
      valid_d = burst_i.load;
      extra_d = burst_i.extra;
      row_d   = burst_i.row_end;
      byte_d  = burst_i.first_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      extra_q <= '0;
      row_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      extra_q <= extra_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign stat_o.more = extra_q != '0;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = row_q && (extra_q == '0);

endmodule

@@ rtl/core/mono_bitmap_row_packer_unit.sv @@
// Top level of the monochrome 1 bpp bitmap row packer.
`timescale 1ns / 1ps

// Takes one RGB pixel per transaction and thresholds it (r+g+b >= 384 is white, bit 1),
// packing 8 pixels per output byte with the first pixel in bit 7. At the end of each row
// (cfg image_width pixels, reset 720, 0 means 65536) the row is zero padded to a 32-bit
// boundary and the last byte carries tlast. Sustained rate is one pixel per cycle while
// the output is ready; a row end emits up to 4 bytes through the single output byte
// register, so input stalls while the padding bytes drain.
module mono_bitmap_row_packer_unit import mbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // packed_byte [7:0]
  output logic        m_axis_tlast_o
);

  pixel_t    in_pix;
  pixel_t    pix;
  logic      pix_valid;
  logic      burst_free;
  logic      advance;
  burst_t    burst;
  out_stat_t out_stat;

  assign in_pix.red   = s_axis_tdata_i[7:0];
  assign in_pix.green = s_axis_tdata_i[15:8];
  assign in_pix.blue  = s_axis_tdata_i[23:16];
  assign advance      = pix_valid && burst_free;

  mbrp_pixel_reg u_pixel_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_pixel_i  (in_pix),
    .pix_valid_o (pix_valid),
    .pix_take_i  (advance),
    .pix_o       (pix)
  );

  mbrp_row_packer u_row_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .pix_i       (pix),
    .burst_o     (burst)
  );

  mbrp_byte_out u_byte_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .free_o      (burst_free),
    .stat_o      (out_stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  a_burst_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst.load |-> advance)
    else $error("burst loaded without a pixel");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid && m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted into a full pipeline");

  a_padding_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && out_stat.more)
      |=> (m_axis_tvalid_o && (m_axis_tdata_o == '0)))
    else $error("padding byte missing or nonzero");

  a_more_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_stat.more) |-> !m_axis_tlast_o)
    else $error("row end flagged before padding done");
`endif

endmodule
